>>> sv/spll_pkg.sv
// spll_pkg: shared constants and types for the SPI length-prefixed packet link
// no dependencies; used by the top level and its port checker
`timescale 1ns / 1ps

package spll_pkg;

    localparam int FIFO_DEPTH_DEF = 64;

    localparam int BYTE_W        = 8;
    localparam int OP_W          = 2;
    localparam int LEVEL_W       = 7;
    localparam int S_TDATA_W     = 8;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 32;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_READY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd2;

    localparam logic [1:0] POS_IDLE    = 2'd0;
    localparam logic [1:0] POS_LENGTH  = 2'd1;
    localparam logic [1:0] POS_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] queue_level;
        logic               enqueue_dropped;
        logic               packet_done;
        logic               request_on;
        logic [BYTE_W-1:0]  rx_byte;
        logic               rx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               tx_valid;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

>>> sv/spi_length_prefixed_packet_link.sv
// Master side of a length-prefixed SPI packet link: every input beat (enqueue,
// peer ready or received SPI byte) yields exactly one registered result beat, and
// a new beat is taken on every clock unless the skid stage is full. The result
// leaves through an output register backed by a one-entry skid stage, so
// s_tready only drops after two results are left waiting on m_tready. The
// transmit FIFO lives in a memory with a registered read port; the head byte
// and the byte after it are kept in registers, so a pop never waits on the read port.
// The FIFO needs no clearing after reset. Depends on spll_pkg.
`timescale 1ns / 1ps

module spi_length_prefixed_packet_link
    import spll_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // data_byte[7:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // operation[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tx_valid[0], tx_byte[8:1], rx_valid[9], rx_byte[17:10], request_on[18],
    // packet_done[19], enqueue_dropped[20], queue_level[27:21], zeros above
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // fifo storage and pointers
    logic [BYTE_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] head_val_reg, head_val_next;
    logic [BYTE_W-1:0] second_val_reg;
    logic [PTR_W-1:0]  rd_addr;

    // link state
    logic [1:0]        pos_reg, pos_next;
    logic [BYTE_W-1:0] in_left_reg, in_left_next;
    logic [BYTE_W-1:0] out_left_reg, out_left_next;
    logic              req_reg, req_next;

    // output register and skid stage
    logic              out_valid_reg, skid_valid_reg;
    result_t           out_reg, skid_reg;
    result_t           res;

    logic              accept, take;
    logic              push, pop, drive;
    logic [1:0]        drv_pos;
    logic [BYTE_W-1:0] data_byte;
    logic [OP_W-1:0]   operation;

    assign data_byte = s_tdata[BYTE_W-1:0];
    assign operation = s_tuser[OP_W-1:0];
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign take      = out_valid_reg && m_tready;

    always_comb begin
        res           = '0;
        push          = 1'b0;
        pop           = 1'b0;
        drive         = 1'b0;
        drv_pos       = pos_reg;
        pos_next      = pos_reg;
        in_left_next  = in_left_reg;
        out_left_next = out_left_reg;
        req_next      = req_reg;

        case (operation)
            OP_ENQUEUE: begin
                if (count_reg == CNT_W'(FIFO_DEPTH)) begin
                    res.enqueue_dropped = 1'b1;
                end else begin
                    push = 1'b1;
                end
            end
            OP_READY: begin
                req_next = 1'b1;
                drive    = 1'b1;
            end
            OP_RX_BYTE: begin
                if (pos_reg == POS_LENGTH) begin
                    in_left_next = data_byte;
                    if (data_byte != '0) begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = data_byte;
                    end
                end else if (pos_reg == POS_PAYLOAD && in_left_reg != '0) begin
                    res.rx_valid = 1'b1;
                    res.rx_byte  = data_byte;
                    in_left_next = in_left_reg - 1'b1;
                end
                if (in_left_next != '0 || out_left_reg != '0 || pos_reg == POS_IDLE) begin
                    if (pos_reg != POS_PAYLOAD) begin
                        pos_next = pos_reg + 1'b1;
                    end
                    drv_pos = pos_next;
                    drive   = 1'b1;
                end else begin
                    pos_next        = POS_IDLE;
                    in_left_next    = '0;
                    out_left_next   = '0;
                    req_next        = 1'b0;
                    res.packet_done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // next byte onto the wire: length, payload or filler
        if (drive) begin
            res.tx_valid = 1'b1;
            if (drv_pos == POS_IDLE && count_reg != '0
                    && CMP_W'(head_val_reg) < CMP_W'(count_reg)) begin
                pop           = 1'b1;
                out_left_next = head_val_reg;
                res.tx_byte   = head_val_reg;
            end else if (out_left_reg != '0) begin
                out_left_next = out_left_reg - 1'b1;
                if (count_reg != '0) begin
                    pop         = 1'b1;
                    res.tx_byte = head_val_reg;
                end
            end
        end

        res.request_on = req_next;
    end

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        head_val_next = head_val_reg;
        if (accept && push) begin
            tail_next  = ptr_inc(tail_reg);
            count_next = count_reg + 1'b1;
            if (count_reg == '0) begin
                head_val_next = data_byte;
            end
        end else if (accept && pop) begin
            head_next     = ptr_inc(head_reg);
            count_next    = count_reg - 1'b1;
            head_val_next = second_val_reg;
        end
        rd_addr = ptr_inc(head_next);
    end

    // memory with registered read of the entry behind the head
    always_ff @(posedge aclk) begin
        if (accept && push) begin
            mem[tail_reg] <= data_byte;
        end
        if (accept && push && tail_reg == rd_addr) begin
            second_val_reg <= data_byte;
        end else begin
            second_val_reg <= mem[rd_addr];
        end
        head_val_reg <= head_val_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            pos_reg      <= POS_IDLE;
            in_left_reg  <= '0;
            out_left_reg <= '0;
            req_reg      <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (accept) begin
                pos_reg      <= pos_next;
                in_left_reg  <= in_left_next;
                out_left_reg <= out_left_next;
                req_reg      <= req_next;
            end
        end
    end

    // result beat with queue level after the step
    result_t res_full;
    always_comb begin
        res_full             = res;
        res_full.queue_level = LEVEL_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!out_valid_reg || take) begin
                out_reg <= res_full;
            end else begin
                skid_reg <= res_full;
            end
        end else if (take && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule

>>> sv/spll_checker.sv
// spll_checker: port-level checks for spi_length_prefixed_packet_link
// depends on spll_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module spll_checker
    import spll_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // tdata bit positions
    localparam int TXV  = 0;
    localparam int RXV  = 9;
    localparam int REQ  = 18;
    localparam int DONE = 19;
    localparam int DROP = 20;

    // in the cycle after an accepted beat, the result side is valid
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat without result");

    // a stalled result beat holds its valid and data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // end of exchange drops request and drives nothing
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DONE] |-> !m_tdata[REQ] && !m_tdata[TXV])
        else $error("packet done with link still active");

    // a dropped enqueue touches neither direction of the link
    a_drop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DROP] |-> !m_tdata[TXV] && !m_tdata[RXV] && !m_tdata[DONE])
        else $error("dropped enqueue moved link traffic");

    // input stalls only while results are backed up
    a_stall_backed: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
        else $error("input stalled with no pending result");

endmodule

bind spi_length_prefixed_packet_link spll_checker u_spll_checker (.*);
